@@ hdl/framed_packet_receiver_crc16_unit_macros.svh @@
// Assertion macros shared by the framed packet receiver RTL.
`ifndef FRAMED_PACKET_RECEIVER_CRC16_UNIT_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CRC16_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fpr_pkg.sv @@
// Constants, codes and the bytewise CRC-16 update for the framed packet receiver.
package fpr_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] START_BYTE_RST = 8'd126;
  localparam logic [7:0] END_BYTE_RST   = 8'd127;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd64;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_START_BYTE = 2'd0;
  localparam reg_idx_t REG_END_BYTE   = 2'd1;
  localparam reg_idx_t REG_MAX_LENGTH = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_CRC_ERR = 2'd1;
  localparam status_t STATUS_NO_END = 2'd2;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/framed_packet_receiver_crc16_unit.sv @@
// Framed packet receiver: start, length, payload, CRC high/low, end byte; CRC-16 check.
// A byte passes the input register, the bytewise CRC update, then the result register.
// Throughput: one byte per cycle, unless an undrained result holds the input.
// A byte that closes no frame still takes one slot of the processing stage.
// Reset (rst_n low, synchronous): parser hunts for the start byte, CRC = 0xFFFF,
// registers return to start 126, end 127, max length 64; both stages are emptied.
module framed_packet_receiver_crc16_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  fpr_pkg::reg_idx_t    cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpr_pkg::status_t     out_status,
  output logic [7:0]           out_frame_length,
  output logic [15:0]          out_received_crc,
  output logic [15:0]          out_computed_crc
);

  `include "framed_packet_receiver_crc16_unit_macros.svh"

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_HI  = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  logic [7:0]  start_byte_r, end_byte_r, max_length_r;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  crc_upper_r, crc_upper_nxt;
  logic [15:0] frame_crc_r, frame_crc_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;

  logic             out_valid_r;
  fpr_pkg::status_t out_status_r, status_nxt;
  logic [7:0]       out_frame_length_r;
  logic [15:0]      out_received_crc_r, out_computed_crc_r;

  logic advance;
  logic res_fire;
  logic end_step;
  logic in_payload;

  // Process the held byte when the result register is free or being drained.
  assign advance  = in_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign end_step   = advance && (phase_r == PH_END);
  assign in_payload = (phase_r == PH_PAYLOAD);

  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    frame_len_nxt   = frame_len_r;
    crc_upper_nxt   = crc_upper_r;
    frame_crc_nxt   = frame_crc_r;
    running_crc_nxt = running_crc_r;
    status_nxt      = fpr_pkg::STATUS_OK;
    res_fire        = 1'b0;
    case (phase_r)
      PH_LENGTH: begin
        if (in_byte_r == 8'd0 || in_byte_r > max_length_r) begin
          phase_nxt = PH_START;
        end else begin
          frame_len_nxt = in_byte_r;
          phase_nxt     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        running_crc_nxt = fpr_pkg::crc16_byte(running_crc_r, in_byte_r);
        byte_count_nxt  = byte_count_r + 8'd1;
        if (byte_count_nxt >= frame_len_r) begin
          phase_nxt = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_upper_nxt = in_byte_r;
        phase_nxt     = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        frame_crc_nxt = {crc_upper_r, in_byte_r};
        phase_nxt     = PH_END;
      end
      PH_END: begin
        res_fire  = 1'b1;
        phase_nxt = PH_START;
        if (in_byte_r != end_byte_r) begin
          status_nxt = fpr_pkg::STATUS_NO_END;
        end else if (running_crc_r == frame_crc_r) begin
          status_nxt = fpr_pkg::STATUS_OK;
        end else begin
          status_nxt = fpr_pkg::STATUS_CRC_ERR;
        end
      end
      default: begin
        phase_nxt = PH_START;
        if (in_byte_r == start_byte_r) begin
          byte_count_nxt  = 8'd0;
          running_crc_nxt = fpr_pkg::CRC_INIT;
          phase_nxt       = PH_LENGTH;
        end
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= fpr_pkg::START_BYTE_RST;
      end_byte_r   <= fpr_pkg::END_BYTE_RST;
      max_length_r <= fpr_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fpr_pkg::REG_START_BYTE: start_byte_r <= cfg_data;
        fpr_pkg::REG_END_BYTE:   end_byte_r   <= cfg_data;
        fpr_pkg::REG_MAX_LENGTH: max_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  // Parser state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_START;
      byte_count_r  <= 8'd0;
      frame_len_r   <= 8'd0;
      crc_upper_r   <= 8'd0;
      frame_crc_r   <= 16'd0;
      running_crc_r <= fpr_pkg::CRC_INIT;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        phase_r       <= phase_nxt;
        byte_count_r  <= byte_count_nxt;
        frame_len_r   <= frame_len_nxt;
        crc_upper_r   <= crc_upper_nxt;
        frame_crc_r   <= frame_crc_nxt;
        running_crc_r <= running_crc_nxt;
      end
      if (advance && res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      out_status_r       <= status_nxt;
      out_frame_length_r <= frame_len_r;
      out_received_crc_r <= frame_crc_r;
      out_computed_crc_r <= running_crc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_frame_length = out_frame_length_r;
  assign out_received_crc = out_received_crc_r;
  assign out_computed_crc = out_computed_crc_r;

  `FPR_ASSERT_NEXT(a_end_to_hunt, end_step, phase_r == PH_START, "no hunt after end")
  `FPR_ASSERT_SAME(a_len_nonzero, in_payload, frame_len_r != 8'd0, "zero length in payload")
  `FPR_ASSERT_SAME(a_count_lt_len, in_payload, byte_count_r < frame_len_r, "count past length")
  `FPR_ASSERT_SAME(a_res_from_end, $rose(out_valid_r), $past(end_step), "result without end")

endmodule

@@ verif/tb_framed_packet_receiver_crc16_unit.sv @@
// Testbench for the framed packet receiver: random and directed byte streams against a predictor.
module tb_framed_packet_receiver_crc16_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    HUNT, GET_LEN, GET_PAYLOAD, GET_CRC_HI, GET_CRC_LO, GET_END
  } parse_t;

  typedef struct {
    fpr_pkg::status_t status;
    logic [7:0]       length;
    logic [15:0]      carried;
    logic [15:0]      computed;
  } frame_report_t;

  typedef logic [7:0] byte_q_t[$];

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  fpr_pkg::reg_idx_t cfg_index = fpr_pkg::REG_START_BYTE;
  logic [7:0]        cfg_data  = 8'h00;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        in_byte   = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  fpr_pkg::status_t  out_status;
  logic [7:0]        out_frame_length;
  logic [15:0]       out_received_crc;
  logic [15:0]       out_computed_crc;

  // Predictor copy of the registers and the parser state
  logic [7:0]  cfg_start   = fpr_pkg::START_BYTE_RST;
  logic [7:0]  cfg_end     = fpr_pkg::END_BYTE_RST;
  logic [7:0]  cfg_max     = fpr_pkg::MAX_LENGTH_RST;
  parse_t      ps          = HUNT;
  logic [7:0]  seen_count  = 8'd0;
  logic [7:0]  want_len    = 8'd0;
  logic [7:0]  crc_hi_q    = 8'd0;
  logic [15:0] carried_crc = 16'h0000;
  logic [15:0] payload_crc = fpr_pkg::CRC_INIT;

  frame_report_t pending_reports[$];

  int fail_count     = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  framed_packet_receiver_crc16_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_received_crc (out_received_crc),
    .out_computed_crc (out_computed_crc)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Bit-serial CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ data[k];
      r  = {r[14:0], 1'b0} ^ (fb ? fpr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", what);
    end
  endtask

  // Advance the parser by one accepted byte and queue the report it closes, if any
  task automatic track_byte(input logic [7:0] b);
    frame_report_t rep;
    case (ps)
      GET_LEN: begin
        if (b == 8'd0 || b > cfg_max) begin
          ps = HUNT;
        end else begin
          want_len = b;
          ps       = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        payload_crc = crc_next(payload_crc, b);
        seen_count  = seen_count + 8'd1;
        if (seen_count >= want_len) begin
          ps = GET_CRC_HI;
        end
      end
      GET_CRC_HI: begin
        crc_hi_q = b;
        ps       = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        carried_crc = {crc_hi_q, b};
        ps          = GET_END;
      end
      GET_END: begin
        if (b != cfg_end) begin
          rep.status = fpr_pkg::STATUS_NO_END;
        end else if (payload_crc == carried_crc) begin
          rep.status = fpr_pkg::STATUS_OK;
        end else begin
          rep.status = fpr_pkg::STATUS_CRC_ERR;
        end
        rep.length   = want_len;
        rep.carried  = carried_crc;
        rep.computed = payload_crc;
        pending_reports.push_back(rep);
        ps = HUNT;
      end
      default: begin
        ps = HUNT;
        if (b == cfg_start) begin
          seen_count  = 8'd0;
          payload_crc = fpr_pkg::CRC_INIT;
          ps          = GET_LEN;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_byte(b);
    items_sent++;
  endtask

  // Drop valid and hold until every queued report has come back and the pipe is empty
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_reports.size() != 0) begin
      note_failure($sformatf("%0d frame reports never arrived", pending_reports.size()));
      pending_reports.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input fpr_pkg::reg_idx_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      fpr_pkg::REG_START_BYTE: cfg_start = value;
      fpr_pkg::REG_END_BYTE:   cfg_end   = value;
      fpr_pkg::REG_MAX_LENGTH: cfg_max   = value;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Send start, length, body, CRC and end byte; a keep in 1..size-1 cuts the frame short
  task automatic send_frame(input byte_q_t body, input logic [15:0] crc_flip,
                            input bit end_ok, input int keep);
    byte_q_t     line_q;
    logic [15:0] crc;
    int          n;
    crc = fpr_pkg::CRC_INIT;
    foreach (body[i]) crc = crc_next(crc, body[i]);
    crc ^= crc_flip;
    line_q.push_back(cfg_start);
    line_q.push_back(8'(body.size()));
    foreach (body[i]) line_q.push_back(body[i]);
    line_q.push_back(crc[15:8]);
    line_q.push_back(crc[7:0]);
    line_q.push_back(end_ok ? cfg_end : cfg_end ^ 8'($urandom_range(1, 255)));
    n = (keep > 0 && keep < line_q.size()) ? keep : line_q.size();
    for (int i = 0; i < n; i++) push_byte(line_q[i]);
  endtask

  function automatic byte_q_t random_body();
    byte_q_t body;
    int      len;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 2) begin
      len = cfg_max;
    end else if (pick < 7) begin
      len = $urandom_range(1, cfg_max);
    end else begin
      len = $urandom_range(1, (cfg_max < 8) ? cfg_max : 8);
    end
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(7);
      if (pick == 0) begin
        body.push_back(cfg_start);
      end else if (pick == 1) begin
        body.push_back(cfg_end);
      end else begin
        body.push_back(8'($urandom_range(255)));
      end
    end
    return body;
  endfunction

  task automatic test_directed();
    byte_q_t body;
    // bytes outside a frame are ignored
    push_byte(8'h00);
    push_byte(8'hFF);
    body = {8'h00};
    send_frame(body, 16'h0000, 1'b1, 0);
    body = {8'hFF};
    send_frame(body, 16'h8001, 1'b1, 0);
    push_byte(cfg_start);
    push_byte(8'd0);
    push_byte(cfg_start);
    push_byte(cfg_max + 8'd1);
    body = {8'hA5};
    send_frame(body, 16'h0000, 1'b0, 0);
    settle();
  endtask

  task automatic test_zero_max_length();
    byte_q_t body;
    write_reg(fpr_pkg::REG_MAX_LENGTH, 8'd0);
    push_byte(cfg_start);
    push_byte(8'd1);
    push_byte(cfg_start);
    push_byte(8'd255);
    body = {8'h42};
    send_frame(body, 16'h0000, 1'b1, 0);
    settle();
    write_reg(fpr_pkg::REG_MAX_LENGTH, fpr_pkg::MAX_LENGTH_RST);
  endtask

  task automatic test_config_mid_frame();
    byte_q_t     body;
    logic [15:0] crc;
    body = {8'h3C, 8'hC3, 8'h7E};
    crc  = fpr_pkg::CRC_INIT;
    foreach (body[i]) crc = crc_next(crc, body[i]);
    push_byte(cfg_start);
    push_byte(8'd3);
    push_byte(body[0]);
    push_byte(body[1]);
    settle();
    // rewrite every register under the open frame; it must close on the new end byte
    write_reg(fpr_pkg::REG_START_BYTE, 8'h11);
    write_reg(fpr_pkg::REG_END_BYTE, 8'h5A);
    write_reg(fpr_pkg::REG_MAX_LENGTH, 8'd2);
    push_byte(body[2]);
    push_byte(crc[15:8]);
    push_byte(crc[7:0]);
    push_byte(8'h5A);
    settle();
  endtask

  task automatic test_random_traffic(input logic [7:0] sb, input logic [7:0] eb,
                                     input logic [7:0] mx, input int idle_pct,
                                     input int stall_pct, input int n_items);
    int      first;
    int      pick;
    byte_q_t body;
    settle();
    write_reg(fpr_pkg::REG_START_BYTE, sb);
    write_reg(fpr_pkg::REG_END_BYTE, eb);
    write_reg(fpr_pkg::REG_MAX_LENGTH, mx);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_frame(random_body(), 16'h0000, 1'b1, 0);
      end else if (pick < 71) begin
        send_frame(random_body(), 16'($urandom_range(1, 65535)), 1'b1, 0);
      end else if (pick < 78) begin
        send_frame(random_body(), 16'h0000, 1'b0, 0);
      end else if (pick < 85) begin
        push_byte(cfg_start);
        if (cfg_max == 8'd255 || $urandom_range(1) == 0) begin
          push_byte(8'd0);
        end else begin
          push_byte(8'($urandom_range(int'(cfg_max) + 1, 255)));
        end
      end else if (pick < 92) begin
        body = random_body();
        send_frame(body, 16'h0000, 1'b1, $urandom_range(1, body.size() + 4));
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      end
      // now and then hold the sender until the block has fully drained
      if ($urandom_range(24) == 0) begin
        settle();
      end
    end
    settle();
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        note_failure($sformatf("unexpected report: status %0d len %0d rx %04h calc %04h",
                               out_status, out_frame_length, out_received_crc,
                               out_computed_crc));
      end else begin
        want = pending_reports.pop_front();
        if (out_status !== want.status || out_frame_length !== want.length ||
            out_received_crc !== want.carried || out_computed_crc !== want.computed) begin
          note_failure($sformatf(
            "mismatch: expected status %0d len %0d rx %04h calc %04h, got %0d %0d %04h %04h",
            want.status, want.length, want.carried, want.computed,
            out_status, out_frame_length, out_received_crc, out_computed_crc));
        end
      end
    end
  end

  initial begin
    logic [7:0] rnd_start;
    logic [7:0] rnd_end;
    logic [7:0] rnd_max;
    rnd_start = 8'($urandom_range(255));
    rnd_end   = 8'($urandom_range(255));
    rnd_max   = 8'($urandom_range(2, 32));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_zero_max_length();
    test_config_mid_frame();
    test_random_traffic(fpr_pkg::START_BYTE_RST, fpr_pkg::END_BYTE_RST,
                        fpr_pkg::MAX_LENGTH_RST, 0, 0, 280);
    test_random_traffic(8'h00, 8'hFF, 8'd255, 58, 0, 280);
    test_random_traffic(8'hFF, 8'h00, 8'd1, 0, 58, 280);
    test_random_traffic(rnd_start, rnd_end, rnd_max, 29, 29, 280);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
